[hw/rtl/udcdb_pkg.sv]
// types, constants and the hex segment table shared by the up/down counter blocks
// no dependencies
package udcdb_pkg;

	localparam int unsigned CountW  = 8;
	localparam int unsigned TimeW   = 16;
	localparam int unsigned SegW    = 7;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;

	localparam logic [CountW-1:0] CountFull = 8'hFF;
	localparam logic [CountW-1:0] CountZero = 8'h00;

	// register reset values
	localparam logic [TimeW-1:0]  LowPeriodRst  = 16'd764;
	localparam logic [TimeW-1:0]  HighPeriodRst = 16'd270;
	localparam logic [TimeW-1:0]  LowLengthRst  = 16'd200;
	localparam logic [TimeW-1:0]  HighLengthRst = 16'd400;
	localparam logic [CountW-1:0] ReportRst     = 8'd5;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_LOW_PERIOD  = 3'd0,
		CFG_HIGH_PERIOD = 3'd1,
		CFG_LOW_LENGTH  = 3'd2,
		CFG_HIGH_LENGTH = 3'd3,
		CFG_REPORT      = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		KIND_SCAN = 1'b0,
		KIND_FINE = 1'b1
	} item_kind_t;

	// one input item as held in the input register
	typedef struct packed {
		item_kind_t kind;
		logic       press_down;
		logic       press_up;
		logic       press_preset;
	} in_item_t;

	// burst start request from the scan logic to the tone logic
	typedef struct packed {
		logic start;
		logic high;
	} tone_start_t;

	// tone configuration for the tone logic
	typedef struct packed {
		logic [TimeW-1:0] low_period;
		logic [TimeW-1:0] high_period;
		logic [TimeW-1:0] low_length;
		logic [TimeW-1:0] high_length;
	} tone_cfg_t;

	// tone state seen by the result register
	typedef struct packed {
		logic pin_a;
		logic pin_b;
		logic busy;
	} tone_stat_t;

	// active-low segments a..g in bits 0..6
	function automatic logic [SegW-1:0] hex_segments(input logic [3:0] nib);
		logic [SegW-1:0] seg;
		unique case (nib)
			4'h0: seg = 7'h40;
			4'h1: seg = 7'h79;
			4'h2: seg = 7'h24;
			4'h3: seg = 7'h30;
			4'h4: seg = 7'h19;
			4'h5: seg = 7'h12;
			4'h6: seg = 7'h02;
			4'h7: seg = 7'h78;
			4'h8: seg = 7'h00;
			4'h9: seg = 7'h10;
			4'hA: seg = 7'h08;
			4'hB: seg = 7'h03;
			4'hC: seg = 7'h46;
			4'hD: seg = 7'h21;
			4'hE: seg = 7'h06;
			4'hF: seg = 7'h0E;
			default: seg = 7'h7F;
		endcase
		return seg;
	endfunction

endpackage

[hw/rtl/up_down_counter_display_buzzer_core.sv]
// top level of the up/down counter with hex segment patterns and buzzer
// depends on udcdb_pkg, udcdb_scan and udcdb_tone
//
// usage
//   s_axis carries one item per handshake: tuser is the kind (0 scan tick,
//   1 fine tone-clock tick), tdata holds the three button levels.
//   m_axis returns exactly one result item for every input item, in order.
//   cfg_we/cfg_index/cfg_data write the five timing registers; write them
//   only while no item is in flight, an index beyond the list is dropped.
// timing
//   an accepted item is held in the input register, then its state
//   update and result are formed in one pass and land in the result
//   register as soon as that register is free; m_axis_tvalid rises
//   when the result register loads the item.
//   one item per cycle sustained while m_axis_tready stays high; the single
//   pass of counter and tone logic between input and result register sets that figure.
// reset
//   arst_n clears both registers' valid flags, the counter, the divider
//   and the tone state, and loads the register defaults.
// stall
//   while m_axis_tready is low the result is held; one more item waits in
//   the input register, after which s_axis_tready drops.
module up_down_counter_display_buzzer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // press_down, press_up, press_preset, zero fill
	input  logic                             s_axis_tuser,  // cmd
	// master side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// count_value[7:0], upper_segments[14:8], lower_segments[21:15], buzzer_a[22],
	// buzzer_b[23], tone_busy[24], report_strobe[25], zero fill
	output logic [31:0]                      m_axis_tdata,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [udcdb_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [udcdb_pkg::CfgW-1:0]       cfg_data
);

	// configuration registers
	udcdb_pkg::tone_cfg_t             tone_cfg_q;
	logic [udcdb_pkg::CountW-1:0]     report_q;

	// input register
	udcdb_pkg::in_item_t              item_s1;
	logic                             valid_s1;

	// result register
	logic                             out_valid_q;
	logic [31:0]                      out_data_q;

	logic                             advance;
	logic                             step;
	logic [udcdb_pkg::CountW-1:0]     count_next;
	logic                             strobe;
	udcdb_pkg::tone_start_t           tone_start;
	udcdb_pkg::tone_stat_t            tone_stat;

	// result register frees up when empty or being taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_cfg_q.low_period  <= udcdb_pkg::LowPeriodRst;
			tone_cfg_q.high_period <= udcdb_pkg::HighPeriodRst;
			tone_cfg_q.low_length  <= udcdb_pkg::LowLengthRst;
			tone_cfg_q.high_length <= udcdb_pkg::HighLengthRst;
			report_q               <= udcdb_pkg::ReportRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				udcdb_pkg::CFG_LOW_PERIOD:  tone_cfg_q.low_period  <= cfg_data;
				udcdb_pkg::CFG_HIGH_PERIOD: tone_cfg_q.high_period <= cfg_data;
				udcdb_pkg::CFG_LOW_LENGTH:  tone_cfg_q.low_length  <= cfg_data;
				udcdb_pkg::CFG_HIGH_LENGTH: tone_cfg_q.high_length <= cfg_data;
				udcdb_pkg::CFG_REPORT:      report_q <= cfg_data[udcdb_pkg::CountW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind         <= udcdb_pkg::item_kind_t'(s_axis_tuser);
			item_s1.press_down   <= s_axis_tdata[0];
			item_s1.press_up     <= s_axis_tdata[1];
			item_s1.press_preset <= s_axis_tdata[2];
		end
	end

	udcdb_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (step),
		.item            (item_s1),
		.report_interval (report_q),
		.count_next      (count_next),
		.strobe          (strobe),
		.tone_start      (tone_start)
	);

	udcdb_tone u_tone (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (step),
		.kind       (item_s1.kind),
		.tone_start (tone_start),
		.cfg        (tone_cfg_q),
		.stat_next  (tone_stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {6'd0, strobe, tone_stat.busy, tone_stat.pin_b, tone_stat.pin_a,
				udcdb_pkg::hex_segments(count_next[3:0]),
				udcdb_pkg::hex_segments(count_next[7:4]),
				count_next};
		end
	end

	// the two pins never sit high together
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[22] && out_data_q[23]))
		else $error("buzzer pins both high");

	// segment patterns follow the count in the same result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[14:8] == udcdb_pkg::hex_segments(out_data_q[7:4])
			&& out_data_q[21:15] == udcdb_pkg::hex_segments(out_data_q[3:0])))
		else $error("segment pattern does not match count");

	// a held input item is not lost while the result stage stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register dropped an item");

	// strobe only comes from a scan tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.kind == udcdb_pkg::KIND_FINE) |=> !out_data_q[25])
		else $error("report strobe on a fine tick");

endmodule

[hw/rtl/udcdb_scan.sv]
// counter, preset toggle and report divider, updated on scan ticks
// depends on udcdb_pkg
module udcdb_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  udcdb_pkg::in_item_t              item,
	input  logic [udcdb_pkg::CountW-1:0]     report_interval,
	output logic [udcdb_pkg::CountW-1:0]     count_next,
	output logic                             strobe,
	output udcdb_pkg::tone_start_t           tone_start
);

	logic [udcdb_pkg::CountW-1:0] counter_q;
	logic [udcdb_pkg::CountW-1:0] scan_count_q;
	logic                         preset_zero_q;
	logic [udcdb_pkg::CountW-1:0] after_down;
	logic [udcdb_pkg::CountW-1:0] after_up;
	logic                         is_scan;

	assign is_scan = (item.kind == udcdb_pkg::KIND_SCAN);

	always_comb begin
		tone_start = '0;
		after_down = counter_q;
		if (item.press_down) begin
			if (counter_q == udcdb_pkg::CountZero) begin
				tone_start.start = 1'b1;
				tone_start.high  = 1'b0;
			end else begin
				after_down = counter_q - 1'b1;
			end
		end
		after_up = after_down;
		if (item.press_up) begin
			if (after_down == udcdb_pkg::CountFull) begin
				tone_start.start = 1'b1;
				tone_start.high  = 1'b1;
			end else begin
				after_up = after_down + 1'b1;
			end
		end
		if (item.press_preset) begin
			count_next = preset_zero_q ? udcdb_pkg::CountZero : udcdb_pkg::CountFull;
		end else begin
			count_next = after_up;
		end
		if (!is_scan) begin
			tone_start = '0;
			count_next = counter_q;
		end
		strobe = is_scan && (scan_count_q == report_interval);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q     <= '0;
			scan_count_q  <= '0;
			preset_zero_q <= 1'b1;
		end else if (advance && is_scan) begin
			counter_q    <= count_next;
			scan_count_q <= strobe ? '0 : scan_count_q + 1'b1;
			if (item.press_preset) begin
				preset_zero_q <= !preset_zero_q;
			end
		end
	end

endmodule

[hw/rtl/udcdb_tone.sv]
// tone burst timer and buzzer pin driver, stepped on fine ticks
// depends on udcdb_pkg
module udcdb_tone (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  udcdb_pkg::item_kind_t  kind,
	input  udcdb_pkg::tone_start_t tone_start,
	input  udcdb_pkg::tone_cfg_t   cfg,
	output udcdb_pkg::tone_stat_t  stat_next
);

	logic                        tone_on_q;
	logic                        tone_high_q;
	logic [udcdb_pkg::TimeW-1:0] period_cnt_q;
	logic [udcdb_pkg::TimeW-1:0] elapse_cnt_q;
	logic                        phase_a_q;
	logic                        pin_a_q;
	logic                        pin_b_q;

	logic [udcdb_pkg::TimeW-1:0] period;
	logic [udcdb_pkg::TimeW-1:0] length;
	logic [udcdb_pkg::TimeW-1:0] period_inc;
	logic [udcdb_pkg::TimeW-1:0] elapse_inc;
	logic                        fine;
	logic                        elapsed;
	logic                        burst_done;

	assign fine       = (kind == udcdb_pkg::KIND_FINE) && tone_on_q;
	assign period     = tone_high_q ? cfg.high_period : cfg.low_period;
	assign length     = tone_high_q ? cfg.high_length : cfg.low_length;
	assign period_inc = period_cnt_q + 1'b1;
	assign elapse_inc = elapse_cnt_q + 1'b1;
	assign elapsed    = (period_inc >= period);
	assign burst_done = (elapse_inc >= length);

	// pins only move on an elapse that does not end the burst
	always_comb begin
		stat_next.pin_a = pin_a_q;
		stat_next.pin_b = pin_b_q;
		stat_next.busy  = tone_on_q;
		if (tone_start.start) begin
			stat_next.busy = 1'b1;
		end else if (fine && elapsed) begin
			if (burst_done) begin
				stat_next.busy = 1'b0;
			end else begin
				stat_next.pin_a = phase_a_q;
				stat_next.pin_b = !phase_a_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_on_q    <= 1'b0;
			tone_high_q  <= 1'b0;
			period_cnt_q <= '0;
			elapse_cnt_q <= '0;
			phase_a_q    <= 1'b1;
			pin_a_q      <= 1'b0;
			pin_b_q      <= 1'b0;
		end else if (advance) begin
			tone_on_q <= stat_next.busy;
			pin_a_q   <= stat_next.pin_a;
			pin_b_q   <= stat_next.pin_b;
			if (tone_start.start) begin
				tone_high_q  <= tone_start.high;
				period_cnt_q <= '0;
				elapse_cnt_q <= '0;
			end else if (fine) begin
				if (elapsed) begin
					period_cnt_q <= '0;
					elapse_cnt_q <= elapse_inc;
					if (!burst_done) begin
						phase_a_q <= !phase_a_q;
					end
				end else begin
					period_cnt_q <= period_inc;
				end
			end
		end
	end

endmodule

[tb/tb_up_down_counter_display_buzzer_core.sv]
// self-checking testbench for up_down_counter_display_buzzer_core
// depends on udcdb_pkg and the core; a scoreboard class predicts every result item
// directed items first, then random phases under several register settings and stall mixes
module tb_up_down_counter_display_buzzer_core;

	import udcdb_pkg::*;

	// cycles with no handshake on either side before the run is called hung
	localparam int StallLimit = 2000;
	// cycles allowed after the last result before registers are touched or the run ends
	localparam int DrainCycles = 3;
	localparam int TailCycles  = 8;
	localparam logic [CfgIdxW-1:0] CfgIdxTop = CfgIdxW'((1 << CfgIdxW) - 1);

	// result item as packed on m_axis_tdata, highest field first
	typedef struct packed {
		logic [5:0]      fill;
		logic            report_strobe;
		logic            tone_busy;
		logic            buzzer_b;
		logic            buzzer_a;
		logic [SegW-1:0] lower_segments;
		logic [SegW-1:0] upper_segments;
		logic [CountW-1:0] count_value;
	} result_t;

	// tracks counter, divider and tone state and holds the results still due
	class counter_tone_board;
		logic [TimeW-1:0]  low_period, high_period, low_length, high_length;
		logic [CountW-1:0] report_every;
		logic [CountW-1:0] count;
		logic [CountW-1:0] scans;
		logic [TimeW-1:0]  ticks, elapses;
		bit                load_zero, tone_on, tone_high, next_a, pin_a, pin_b;
		bit [7:0]          glyphs [16];
		result_t           due_results [$];
		int                failures;

		function new();
			low_period   = LowPeriodRst;
			high_period  = HighPeriodRst;
			low_length   = LowLengthRst;
			high_length  = HighLengthRst;
			report_every = ReportRst;
			count        = '0;
			scans        = '0;
			ticks        = '0;
			elapses      = '0;
			load_zero    = 1'b1;
			tone_on      = 1'b0;
			tone_high    = 1'b0;
			next_a       = 1'b1;
			pin_a        = 1'b0;
			pin_b        = 1'b0;
			failures     = 0;
			// common-anode hex glyphs, bit 7 is the unused point
			glyphs = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
			           8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E};
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
			case (idx)
				CFG_LOW_PERIOD:  low_period   = data;
				CFG_HIGH_PERIOD: high_period  = data;
				CFG_LOW_LENGTH:  low_length   = data;
				CFG_HIGH_LENGTH: high_length  = data;
				CFG_REPORT:      report_every = data[CountW-1:0];
				default: ;
			endcase
		endfunction

		// a new burst restarts the divider but leaves the pins and phase alone
		function void start_burst(bit high);
			tone_on   = 1'b1;
			tone_high = high;
			ticks     = '0;
			elapses   = '0;
		endfunction

		function void take_item(item_kind_t kind, bit dn, bit up, bit pre);
			result_t          r;
			bit               strobe;
			logic [TimeW-1:0] period, length;
			strobe = 1'b0;
			if (kind == KIND_SCAN) begin
				if (dn) begin
					if (count == CountZero) start_burst(1'b0);
					else count = count - 1'b1;
				end
				if (up) begin
					if (count == CountFull) start_burst(1'b1);
					else count = count + 1'b1;
				end
				if (pre) begin
					count     = load_zero ? CountZero : CountFull;
					load_zero = !load_zero;
				end
				strobe = (scans == report_every);
				scans  = strobe ? '0 : scans + 1'b1;
			end else if (tone_on) begin
				period = tone_high ? high_period : low_period;
				length = tone_high ? high_length : low_length;
				ticks  = ticks + 1'b1;
				if (ticks >= period) begin
					ticks   = '0;
					elapses = elapses + 1'b1;
					if (elapses >= length) begin
						tone_on = 1'b0;
					end else begin
						pin_a  = next_a;
						pin_b  = !next_a;
						next_a = !next_a;
					end
				end
			end
			r.fill           = '0;
			r.report_strobe  = strobe;
			r.tone_busy      = tone_on;
			r.buzzer_b       = pin_b;
			r.buzzer_a       = pin_a;
			r.lower_segments = glyphs[count[3:0]][SegW-1:0];
			r.upper_segments = glyphs[count[7:4]][SegW-1:0];
			r.count_value    = count;
			due_results.push_back(r);
		endfunction

		function void check_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0h actual %0h", $time, label, want, got);
				failures++;
			end
		endfunction

		function void match_result(logic [31:0] raw);
			result_t got, want;
			got = raw;
			if (due_results.size() == 0) begin
				$display("%0t: result %0h expected none actual item", $time, raw);
				failures++;
				return;
			end
			want = due_results.pop_front();
			check_field("count_value", want.count_value, got.count_value);
			check_field("upper_segments", want.upper_segments, got.upper_segments);
			check_field("lower_segments", want.lower_segments, got.lower_segments);
			check_field("buzzer_a", want.buzzer_a, got.buzzer_a);
			check_field("buzzer_b", want.buzzer_b, got.buzzer_b);
			check_field("tone_busy", want.tone_busy, got.tone_busy);
			check_field("report_strobe", want.report_strobe, got.report_strobe);
			check_field("fill", want.fill, got.fill);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;

	counter_tone_board board = new();

	// idle percentages of the sender and the receiver, set per phase
	int send_idle_pct = 34;
	int recv_idle_pct = 81;
	int quiet_cycles  = 0;

	up_down_counter_display_buzzer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: check on the handshake seen before the edge, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.match_result(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog: a long run of cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("tb_up_down_counter_display_buzzer_core NOT OK");
				$finish;
			end
		end
	end

	// offer one item, idling first at random, and return once it has been taken;
	// valid stays high so that a back-to-back item follows without a gap
	task automatic send_item(item_kind_t kind, bit dn, bit up, bit pre);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {5'b0, pre, up, dn};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_item(kind, dn, up, pre);
	endtask

	// stop offering items and wait for every result still due
	task automatic hold_off_until_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// registers only change with the core empty; an index past the list rides along
	task automatic write_regs(logic [TimeW-1:0] lp, logic [TimeW-1:0] hp,
	                          logic [TimeW-1:0] ll, logic [TimeW-1:0] hl,
	                          logic [CountW-1:0] ri);
		hold_off_until_drained();
		repeat (DrainCycles) @(posedge clk);
		put_reg(CFG_LOW_PERIOD, lp);
		put_reg(CFG_HIGH_PERIOD, hp);
		put_reg(CFG_LOW_LENGTH, ll);
		put_reg(CFG_HIGH_LENGTH, hl);
		// upper byte is junk and must be dropped
		put_reg(CFG_REPORT, {CfgW'($urandom_range(0, 255)) << CountW} | CfgW'(ri));
		put_reg(CfgIdxW'($urandom_range(CFG_REPORT + 1, CfgIdxTop)),
		        CfgW'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
	endtask

	// mostly short periods so that bursts run to the end, now and then an extreme
	function automatic logic [TimeW-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return TimeW'($urandom_range(1, 65535));
			default: return TimeW'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [TimeW-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return TimeW'($urandom_range(1, 65535));
			default: return TimeW'($urandom_range(0, 8));
		endcase
	endfunction

	initial begin
		int                phase, k, n_items, scan_pct;
		logic [TimeW-1:0]  lp, hp, ll, hl;
		logic [CountW-1:0] ri;
		item_kind_t        kind;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset defaults
		send_item(KIND_SCAN, 1'b0, 1'b0, 1'b0);
		send_item(KIND_FINE, 1'b1, 1'b1, 1'b1);   // no burst, buttons ignored
		send_item(KIND_SCAN, 1'b1, 1'b0, 1'b0);   // down at zero: low tone
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_SCAN, 1'b0, 1'b1, 1'b0);
		send_item(KIND_SCAN, 1'b0, 1'b0, 1'b1);   // preset to zero
		send_item(KIND_SCAN, 1'b0, 1'b0, 1'b1);   // preset to full
		send_item(KIND_SCAN, 1'b0, 1'b1, 1'b0);   // up at full: high tone over the low one
		send_item(KIND_SCAN, 1'b1, 1'b1, 1'b1);   // all three in order

		// zero low period and zero low length, report interval set to zero
		write_regs(16'd0, 16'd3, 16'd0, 16'hFFFF, 8'd0);
		send_item(KIND_SCAN, 1'b1, 1'b0, 1'b0);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);   // elapses at once and stops
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_SCAN, 1'b0, 1'b0, 1'b1);
		send_item(KIND_SCAN, 1'b0, 1'b1, 1'b0);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);

		// period lowered under the running divider count
		write_regs(16'd0, 16'd1, 16'd0, 16'hFFFF, 8'hFF);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);

		// length lowered under the elapse count: burst ends, pins hold
		write_regs(16'd0, 16'd1, 16'd0, 16'd1, 8'hFF);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_FINE, 1'b0, 1'b0, 1'b0);
		send_item(KIND_SCAN, 1'b1, 1'b0, 1'b0);

		// random phases: stall mixes move from sender-light to receiver-light to none
		for (phase = 0; phase < 6; phase++) begin
			send_idle_pct = (phase < 2) ? 34 : (phase < 4) ? 81 : 0;
			recv_idle_pct = (phase < 2) ? 81 : (phase < 4) ? 34 : 0;
			lp = pick_period();
			hp = pick_period();
			ll = pick_length();
			hl = pick_length();
			case ($urandom_range(0, 3))
				0: ri = 8'd0;
				1: ri = 8'hFF;
				default: ri = CountW'($urandom_range(1, 12));
			endcase
			// wide interval, then a small one below the scan count so it must wrap
			if (phase == 2) begin
				lp = 16'hFFFF;
				hl = 16'hFFFF;
				ri = 8'hFF;
			end
			if (phase == 3)
				ri = 8'd3;
			write_regs(lp, hp, ll, hl, ri);
			n_items  = (phase == 3) ? 200 : 110;
			scan_pct = (phase == 2 || phase == 3) ? 90 : 50;
			for (k = 0; k < n_items; k++) begin
				if (phase == 1 && k == n_items / 2)
					hold_off_until_drained();
				kind = ($urandom_range(0, 99) < scan_pct) ? KIND_SCAN : KIND_FINE;
				send_item(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				          $urandom_range(0, 7) == 0);
			end
		end

		hold_off_until_drained();
		repeat (TailCycles) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("tb_up_down_counter_display_buzzer_core OK");
		else
			$display("tb_up_down_counter_display_buzzer_core NOT OK");
		$finish;
	end

endmodule
